// ===== sv/bdll_pkg.sv =====
// bdll_pkg: shared codes, field widths and controller/datapath interface types
// for the bounded doubly linked list; depends on nothing
`default_nettype none

package bdll_pkg;

    // field widths of the request and result beats
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // walk pointer start selection
    localparam logic [1:0] SEL_NIL  = 2'd0;
    localparam logic [1:0] SEL_HEAD = 2'd1;
    localparam logic [1:0] SEL_TAIL = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                set_cur;
        logic [1:0]          cur_sel;
        logic                rd_cur;
        logic                adv;
        logic                ins_w1;
        logic                ins_w2;
        logic                del_w;
        logic                set_found;
        logic                finish;
        logic [STATUS_W-1:0] fin_status;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            ins_pos_bad;
        logic            del_pos_bad;
        logic            first_pos;
        logic            walk_done;
        logic            hit;
        logic            next_nil;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/bdll_ram.sv =====
// bdll_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module bdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/bdll_ctrl.sv =====
// bdll_ctrl: request sequencer for the linked list
// depends on bdll_pkg for command and status types
`default_nettype none

module bdll_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bdll_pkg::dp_sts_t sts,
    output logic                   busy,
    output bdll_pkg::cmd_t         cmd
);

    import bdll_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_WCHK = 4'd2;
    localparam logic [3:0] S_WADV = 4'd3;
    localparam logic [3:0] S_IRD  = 4'd4;
    localparam logic [3:0] S_IW1  = 4'd5;
    localparam logic [3:0] S_IW2  = 4'd6;
    localparam logic [3:0] S_DRD  = 4'd7;
    localparam logic [3:0] S_DW   = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SCMP = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    // state and pending status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.fin_status = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next = ST_OK;
                case (sts.op)
                    OP_INS_FRONT, OP_INS_BACK:
                    begin
                        if (sts.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = (sts.op == OP_INS_FRONT) ? SEL_NIL : SEL_TAIL;
                            state_next  = S_IRD;
                        end
                    end
                    OP_INS_AT:
                    begin
                        if (sts.ins_pos_bad)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_FIN;
                        end
                        else if (sts.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FIN;
                        end
                        else if (sts.first_pos)
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = SEL_NIL;
                            state_next  = S_IRD;
                        end
                        else
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = SEL_HEAD;
                            state_next  = S_WCHK;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK:
                    begin
                        if (sts.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = (sts.op == OP_DEL_FRONT) ? SEL_HEAD : SEL_TAIL;
                            state_next  = S_DRD;
                        end
                    end
                    OP_DEL_AT:
                    begin
                        if (sts.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else if (sts.del_pos_bad)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = SEL_HEAD;
                            state_next  = S_WCHK;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (sts.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.set_cur = 1'b1;
                            cmd.cur_sel = SEL_HEAD;
                            state_next  = S_SRD;
                        end
                    end
                    default:
                    begin
                        st_next    = sts.empty ? ST_EMPTY : ST_OK;
                        state_next = S_FIN;
                    end
                endcase
            end
            // positional walk: check the position, then read and advance one link
            S_WCHK:
            begin
                if (sts.walk_done)
                begin
                    state_next = (sts.op == OP_INS_AT) ? S_IRD : S_DRD;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WADV;
                end
            end
            S_WADV:
            begin
                cmd.adv    = 1'b1;
                state_next = S_WCHK;
            end
            // insert after the walk node
            S_IRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_IW1;
            end
            S_IW1:
            begin
                cmd.ins_w1 = 1'b1;
                state_next = S_IW2;
            end
            S_IW2:
            begin
                cmd.ins_w2 = 1'b1;
                state_next = S_FIN;
            end
            // unlink the walk node
            S_DRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_DW;
            end
            S_DW:
            begin
                cmd.del_w  = 1'b1;
                state_next = S_FIN;
            end
            // search walk
            S_SRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (sts.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FIN;
                end
                else if (sts.next_nil)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bdll_dpath.sv =====
// bdll_dpath: node store, allocation stack, list pointers and result registers
// depends on bdll_pkg and bdll_ram
`default_nettype none

module bdll_dpath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire bdll_pkg::cmd_t                       cmd,
    input  wire logic        [bdll_pkg::OP_W-1:0]     operation,
    input  wire logic        [bdll_pkg::POS_W-1:0]    position,
    input  wire logic signed [bdll_pkg::VAL_W-1:0]    value,
    output bdll_pkg::dp_sts_t                         sts,
    output logic                                      done,
    output logic             [bdll_pkg::STATUS_W-1:0] status,
    output logic                                      found,
    output logic             [bdll_pkg::LEN_W-1:0]    length
);

    import bdll_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    // list state
    logic [IW-1:0] head_reg, tail_reg, cnt_reg, hwm_reg, stk_reg;
    // walk and request registers
    logic [IW-1:0]         cur_reg, n_reg, succ_reg;
    logic [POS_W-1:0]      k_reg, tgt_reg, pos_reg;
    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic                  found_reg, done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  found_out_reg;
    logic [LEN_W-1:0]      length_reg;

    // memory ports
    logic                  val_we, nxt_we, prv_we, stk_we;
    logic [AW-1:0]         val_wa, nxt_wa, prv_wa, stk_wa, stk_ra, rd_a;
    logic [DATA_WIDTH-1:0] val_wd, val_rd;
    logic [IW-1:0]         nxt_wd, nxt_rd, prv_wd, prv_rd, stk_rd;

    logic [IW-1:0] stk_dec, succ_c, n_c;

    assign rd_a    = cur_reg[AW-1:0];
    assign stk_dec = stk_reg - IW'(1);
    assign stk_ra  = stk_dec[AW-1:0];
    assign succ_c  = (cur_reg < NIL) ? nxt_rd : head_reg;
    assign n_c     = (stk_reg != '0) ? stk_rd : hwm_reg;

    bdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(rd_a), .rdata(val_rd)
    );
    bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(rd_a), .rdata(nxt_rd)
    );
    bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prv (
        .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(rd_a), .rdata(prv_rd)
    );
    bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(cur_reg), .raddr(stk_ra), .rdata(stk_rd)
    );

    // memory write selection
    always_comb
    begin
        val_we = cmd.ins_w1;
        val_wa = n_c[AW-1:0];
        val_wd = val_reg;
        nxt_we = 1'b0;
        nxt_wa = n_c[AW-1:0];
        nxt_wd = succ_c;
        prv_we = 1'b0;
        prv_wa = n_c[AW-1:0];
        prv_wd = cur_reg;
        stk_we = cmd.del_w;
        stk_wa = stk_reg[AW-1:0];
        if (cmd.ins_w1)
        begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
        end
        else if (cmd.ins_w2)
        begin
            nxt_we = (cur_reg < NIL);
            nxt_wa = cur_reg[AW-1:0];
            nxt_wd = n_reg;
            prv_we = (succ_reg < NIL);
            prv_wa = succ_reg[AW-1:0];
            prv_wd = n_reg;
        end
        else if (cmd.del_w)
        begin
            nxt_we = (prv_rd < NIL);
            nxt_wa = prv_rd[AW-1:0];
            nxt_wd = nxt_rd;
            prv_we = (nxt_rd < NIL);
            prv_wa = nxt_rd[AW-1:0];
            prv_wd = prv_rd;
        end
    end

    // list pointers, count and allocation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            cnt_reg  <= '0;
            hwm_reg  <= '0;
            stk_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.ins_w1)
            begin
                if (stk_reg != '0)
                begin
                    stk_reg <= stk_dec;
                end
                else
                begin
                    hwm_reg <= hwm_reg + IW'(1);
                end
            end
            if (cmd.ins_w2)
            begin
                if (!(cur_reg < NIL))
                begin
                    head_reg <= n_reg;
                end
                if (!(succ_reg < NIL))
                begin
                    tail_reg <= n_reg;
                end
                cnt_reg <= cnt_reg + IW'(1);
            end
            if (cmd.del_w)
            begin
                if (!(prv_rd < NIL))
                begin
                    head_reg <= nxt_rd;
                end
                if (!(nxt_rd < NIL))
                begin
                    tail_reg <= prv_rd;
                end
                cnt_reg <= cnt_reg - IW'(1);
                stk_reg <= stk_reg + IW'(1);
            end
        end
    end

    // request capture, walk pointer and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            pos_reg   <= position;
            tgt_reg   <= (operation == OP_INS_AT) ? position - POS_W'(1) : position;
            val_reg   <= DATA_WIDTH'(value);
            found_reg <= 1'b0;
        end
        if (cmd.set_found)
        begin
            found_reg <= 1'b1;
        end
        if (cmd.set_cur)
        begin
            k_reg <= POS_W'(1);
            case (cmd.cur_sel)
                SEL_HEAD: cur_reg <= head_reg;
                SEL_TAIL: cur_reg <= tail_reg;
                default:  cur_reg <= NIL;
            endcase
        end
        else if (cmd.adv)
        begin
            cur_reg <= nxt_rd;
            k_reg   <= k_reg + POS_W'(1);
        end
        if (cmd.ins_w1)
        begin
            n_reg    <= n_c;
            succ_reg <= succ_c;
        end
        if (cmd.finish)
        begin
            status_reg    <= cmd.fin_status;
            found_out_reg <= found_reg;
            length_reg    <= LEN_W'(cnt_reg);
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.op          = op_reg;
        sts.empty       = (cnt_reg == '0);
        sts.full        = (cnt_reg == NIL);
        sts.ins_pos_bad = (pos_reg == '0) || (10'(pos_reg) > (10'(cnt_reg) + 10'd1));
        sts.del_pos_bad = (pos_reg == '0) || (10'(pos_reg) > 10'(cnt_reg));
        sts.first_pos   = (pos_reg == POS_W'(1));
        sts.walk_done   = (k_reg == tgt_reg);
        sts.hit         = (val_rd == val_reg);
        sts.next_nil    = !(nxt_rd < NIL);
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign found  = found_out_reg;
    assign length = length_reg;

endmodule

`default_nettype wire

// ===== sv/bounded_doubly_linked_list.sv =====
// Bounded doubly linked list: controller and datapath with a RAM node store.
// A request is decoded and ends in the finish state before done; inserts read the walk node,
// then write the new node and relink its neighbours, deletes read, then unlink, positional
// requests walk link by link first; search compares node by node; all reads are registered.
// One request at a time; busy is high until the done beat, the receiver cannot stall.
// Reset empties the list at once; the node store needs no clearing pass.
`default_nettype none

module bounded_doubly_linked_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [bdll_pkg::OP_W-1:0]     operation,
    input  wire logic        [bdll_pkg::POS_W-1:0]    position,
    input  wire logic signed [bdll_pkg::VAL_W-1:0]    value,
    output logic                                      done,
    output logic             [bdll_pkg::STATUS_W-1:0] status,
    output logic                                      found,
    output logic             [bdll_pkg::LEN_W-1:0]    length
);

    import bdll_pkg::*;

    cmd_t    cmd;
    dp_sts_t sts;

    // sequencer
    bdll_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
    );

    // store and pointers
    bdll_dpath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .operation(operation), .position(position),
        .value(value), .sts(sts), .done(done), .status(status), .found(found),
        .length(length)
    );

    // an accepted request never completes in the next cycle
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("done beat right after accept");

    // full status only with a full store
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (length == LEN_W'(CAPACITY)))
        else $error("full status with spare nodes");

    // empty status reports an empty list and no hit
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (length == '0 && !found))
        else $error("empty status with elements or hit");

    // a hit is always an ok beat
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_OK))
        else $error("found with error status");

endmodule

`default_nettype wire
